### sv/lcdw_pkg.sv
// Shared types, command codes and lookup functions of the LCD window command sequencer.
package lcdw_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned WORD_W      = 16;
	localparam int unsigned OP_W        = 3;
	localparam int unsigned STEP_W      = 4;

	localparam logic [OP_W-1:0] OP_WINDOW  = 3'd0;
	localparam logic [OP_W-1:0] OP_SCAN    = 3'd1;
	localparam logic [OP_W-1:0] OP_PIXEL   = 3'd2;
	localparam logic [OP_W-1:0] OP_READPT  = 3'd3;
	localparam logic [OP_W-1:0] OP_CONVERT = 3'd4;

	localparam logic [WORD_W-1:0] CMD_HSTART = 16'h0050;
	localparam logic [WORD_W-1:0] CMD_HEND   = 16'h0051;
	localparam logic [WORD_W-1:0] CMD_VSTART = 16'h0052;
	localparam logic [WORD_W-1:0] CMD_VEND   = 16'h0053;
	localparam logic [WORD_W-1:0] CMD_CURX   = 16'h0020;
	localparam logic [WORD_W-1:0] CMD_CURY   = 16'h0021;
	localparam logic [WORD_W-1:0] CMD_GRAM   = 16'h0022;
	localparam logic [WORD_W-1:0] CMD_COLSET = 16'h002A;
	localparam logic [WORD_W-1:0] CMD_PAGSET = 16'h002B;
	localparam logic [WORD_W-1:0] CMD_MEMWR  = 16'h002C;
	localparam logic [WORD_W-1:0] CMD_MEMRD  = 16'h002E;
	localparam logic [WORD_W-1:0] CMD_MADCTL = 16'h0036;

	localparam logic [STEP_W-1:0] STEP_CURSOR   = 4'd8;
	localparam logic [STEP_W-1:0] LAST_WIN_REG  = 4'd12;
	localparam logic [STEP_W-1:0] LAST_WIN_BYTE = 4'd10;
	localparam logic [STEP_W-1:0] LAST_SCAN     = 4'd2;
	localparam logic [STEP_W-1:0] LAST_SINGLE   = 4'd0;

	typedef enum logic [2:0] {
		KIND_WIN_REG  = 3'd0,
		KIND_WIN_BYTE = 3'd1,
		KIND_RD_BYTE  = 3'd2,
		KIND_SCAN     = 3'd3,
		KIND_PIXEL    = 3'd4,
		KIND_COLOR    = 3'd5
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [STEP_W-1:0]  first_step;
		logic [WORD_W-1:0]  w0;
		logic [WORD_W-1:0]  w1;
		logic [WORD_W-1:0]  w2;
		logic [WORD_W-1:0]  w3;
		logic [WORD_W-1:0]  w4;
		logic [WORD_W-1:0]  w5;
	} entry_t;

	function automatic logic [7:0] scan_code(input logic [2:0] idx);
		logic [7:0] code;
		case (idx)
			3'd0:    code = 8'h08;
			3'd1:    code = 8'h88;
			3'd2:    code = 8'h48;
			3'd3:    code = 8'hC8;
			3'd4:    code = 8'h28;
			3'd5:    code = 8'h68;
			3'd6:    code = 8'hA8;
			default: code = 8'hE8;
		endcase
		return code;
	endfunction

	function automatic logic [WORD_W-1:0] reg_cmd(input logic [2:0] idx);
		logic [WORD_W-1:0] code;
		case (idx)
			3'd0:    code = CMD_HSTART;
			3'd1:    code = CMD_HEND;
			3'd2:    code = CMD_VSTART;
			3'd3:    code = CMD_VEND;
			3'd4:    code = CMD_CURX;
			3'd5:    code = CMD_CURY;
			default: code = CMD_GRAM;
		endcase
		return code;
	endfunction

endpackage

### sv/lcd_window_command_sequencer.sv
// Top level of the LCD window command sequencer.
//
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------------
//  req     | req_valid / req_stall     | op, x_start .. y_cursor, scan_mode,
//          |                           | pixel_word, read_first, read_second
//  word    | word_valid / word_stall   | is_data, bus_word, is_color, last
//  cfg     | cfg_valid / cfg_ready     | cfg_value (controller type)
//
// A request emits one word per step: 13 for a register-type window, 11 for a
// byte-type window or point read, 5 for a register-type point read, 3 for a scan mode,
// 1 for a pixel or a conversion. The word sequencer emits one word a cycle
// unless word_stall holds it. Requests producing nothing are dropped in the front end.
// Reset clears the controller type to the register-indexed family and empties the queue.
// req_stall rises only while the descriptor queue is full; word_stall holds the output
// register and, once the queue fills, backs up into req_stall.
module lcd_window_command_sequencer #(
	parameter int unsigned QUEUE_DEPTH = lcdw_pkg::QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_value,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [lcdw_pkg::OP_W-1:0]    op,
	input  logic [lcdw_pkg::WORD_W-1:0]  x_start,
	input  logic [lcdw_pkg::WORD_W-1:0]  y_start,
	input  logic [lcdw_pkg::WORD_W-1:0]  x_end,
	input  logic [lcdw_pkg::WORD_W-1:0]  y_end,
	input  logic [lcdw_pkg::WORD_W-1:0]  x_cursor,
	input  logic [lcdw_pkg::WORD_W-1:0]  y_cursor,
	input  logic [3:0]                   scan_mode,
	input  logic [lcdw_pkg::WORD_W-1:0]  pixel_word,
	input  logic [lcdw_pkg::WORD_W-1:0]  read_first,
	input  logic [lcdw_pkg::WORD_W-1:0]  read_second,
	output logic                         word_valid,
	input  logic                         word_stall,
	output logic                         is_data,
	output logic [lcdw_pkg::WORD_W-1:0]  bus_word,
	output logic                         is_color,
	output logic                         last
);

	logic              push_valid;
	logic              push_ready;
	lcdw_pkg::entry_t  push_data;
	logic              head_valid;
	logic              pop;
	lcdw_pkg::entry_t  head_data;

	lcdw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_value   (cfg_value),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.op          (op),
		.x_start     (x_start),
		.y_start     (y_start),
		.x_end       (x_end),
		.y_end       (y_end),
		.x_cursor    (x_cursor),
		.y_cursor    (y_cursor),
		.scan_mode   (scan_mode),
		.pixel_word  (pixel_word),
		.read_first  (read_first),
		.read_second (read_second),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	lcdw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.head_valid (head_valid),
		.pop        (pop),
		.head_data  (head_data)
	);

	lcdw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.is_data    (is_data),
		.bus_word   (bus_word),
		.is_color   (is_color),
		.last       (last)
	);

endmodule

### sv/lcdw_front.sv
// Front end: holds the controller type, classifies requests and pushes descriptors.
module lcdw_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_value,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [lcdw_pkg::OP_W-1:0]     op,
	input  logic [lcdw_pkg::WORD_W-1:0]   x_start,
	input  logic [lcdw_pkg::WORD_W-1:0]   y_start,
	input  logic [lcdw_pkg::WORD_W-1:0]   x_end,
	input  logic [lcdw_pkg::WORD_W-1:0]   y_end,
	input  logic [lcdw_pkg::WORD_W-1:0]   x_cursor,
	input  logic [lcdw_pkg::WORD_W-1:0]   y_cursor,
	input  logic [3:0]                    scan_mode,
	input  logic [lcdw_pkg::WORD_W-1:0]   pixel_word,
	input  logic [lcdw_pkg::WORD_W-1:0]   read_first,
	input  logic [lcdw_pkg::WORD_W-1:0]   read_second,
	output logic                          push_valid,
	input  logic                          push_ready,
	output lcdw_pkg::entry_t              push_data
);

	logic        ctype_q;
	logic        keep;
	logic [3:0]  mode_m1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctype_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			ctype_q <= cfg_value;
		end
	end

	assign mode_m1 = scan_mode - 4'd1;

	always_comb begin
		keep                 = 1'b1;
		push_data.kind       = lcdw_pkg::KIND_PIXEL;
		push_data.first_step = '0;
		push_data.w0         = x_start;
		push_data.w1         = x_end;
		push_data.w2         = y_start;
		push_data.w3         = y_end;
		push_data.w4         = x_cursor;
		push_data.w5         = y_cursor;
		case (op)
			lcdw_pkg::OP_WINDOW: begin
				push_data.kind = ctype_q ? lcdw_pkg::KIND_WIN_BYTE : lcdw_pkg::KIND_WIN_REG;
			end
			lcdw_pkg::OP_SCAN: begin
				push_data.kind = lcdw_pkg::KIND_SCAN;
				push_data.w0   = {8'h00, lcdw_pkg::scan_code(mode_m1[2:0])};
				keep           = (scan_mode != 4'd0) && (scan_mode <= 4'd8);
			end
			lcdw_pkg::OP_PIXEL: begin
				push_data.kind = lcdw_pkg::KIND_PIXEL;
				push_data.w0   = pixel_word;
			end
			lcdw_pkg::OP_READPT: begin
				if (ctype_q) begin
					push_data.kind = lcdw_pkg::KIND_RD_BYTE;
					push_data.w1   = x_start;
					push_data.w3   = y_start;
				end else begin
					push_data.kind       = lcdw_pkg::KIND_WIN_REG;
					push_data.first_step = lcdw_pkg::STEP_CURSOR;
					push_data.w4         = x_start;
					push_data.w5         = y_start;
				end
			end
			lcdw_pkg::OP_CONVERT: begin
				push_data.kind = lcdw_pkg::KIND_COLOR;
				push_data.w0   = ctype_q ?
					{read_first[15:11], read_first[7:2], read_second[15:11]} : read_first;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign req_stall  = !push_ready;
	assign push_valid = req_valid && keep;

endmodule

### sv/lcdw_queue.sv
// Short descriptor queue between the front end and the word sequencer.
module lcdw_queue #(
	parameter int unsigned DEPTH = lcdw_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  lcdw_pkg::entry_t  push_data,
	output logic              head_valid,
	input  logic              pop,
	output lcdw_pkg::entry_t  head_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	lcdw_pkg::entry_t   mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### sv/lcdw_back.sv
// Back end: steps each descriptor, one bus word per cycle unless stalled.
module lcdw_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  lcdw_pkg::entry_t             head_data,
	output logic                         pop,
	output logic                         word_valid,
	input  logic                         word_stall,
	output logic                         is_data,
	output logic [lcdw_pkg::WORD_W-1:0]  bus_word,
	output logic                         is_color,
	output logic                         last
);

	logic                          active_q;
	logic [lcdw_pkg::STEP_W-1:0]   step_q;
	logic [lcdw_pkg::STEP_W-1:0]   cur_step;
	logic [lcdw_pkg::STEP_W-1:0]   last_step;
	logic                          advance;
	logic                          n_data;
	logic                          n_color;
	logic                          n_last;
	logic [lcdw_pkg::WORD_W-1:0]   n_word;
	logic [lcdw_pkg::WORD_W-1:0]   reg_src;
	logic                          valid_q;
	logic                          data_q;
	logic                          color_q;
	logic                          last_q;
	logic [lcdw_pkg::WORD_W-1:0]   word_q;

	assign cur_step = active_q ? step_q : head_data.first_step;

	always_comb begin
		case (cur_step[3:1])
			3'd0:    reg_src = head_data.w0;
			3'd1:    reg_src = head_data.w1;
			3'd2:    reg_src = head_data.w2;
			3'd3:    reg_src = head_data.w3;
			3'd4:    reg_src = head_data.w4;
			default: reg_src = head_data.w5;
		endcase
	end

	always_comb begin
		n_data    = 1'b0;
		n_color   = 1'b0;
		n_word    = head_data.w0;
		last_step = lcdw_pkg::LAST_SINGLE;
		case (head_data.kind)
			lcdw_pkg::KIND_PIXEL: begin
				n_data = 1'b1;
			end
			lcdw_pkg::KIND_COLOR: begin
				n_color = 1'b1;
			end
			lcdw_pkg::KIND_SCAN: begin
				last_step = lcdw_pkg::LAST_SCAN;
				case (cur_step)
					4'd0:    n_word = lcdw_pkg::CMD_MADCTL;
					4'd1:    n_data = 1'b1;
					default: n_word = lcdw_pkg::CMD_MEMWR;
				endcase
			end
			lcdw_pkg::KIND_WIN_REG: begin
				last_step = lcdw_pkg::LAST_WIN_REG;
				if (cur_step[0]) begin
					n_data = 1'b1;
					n_word = reg_src;
				end else begin
					n_word = lcdw_pkg::reg_cmd(cur_step[3:1]);
				end
			end
			lcdw_pkg::KIND_WIN_BYTE, lcdw_pkg::KIND_RD_BYTE: begin
				last_step = lcdw_pkg::LAST_WIN_BYTE;
				case (cur_step)
					4'd0:  n_word = lcdw_pkg::CMD_COLSET;
					4'd5:  n_word = lcdw_pkg::CMD_PAGSET;
					4'd10: n_word = (head_data.kind == lcdw_pkg::KIND_RD_BYTE) ?
						lcdw_pkg::CMD_MEMRD : lcdw_pkg::CMD_MEMWR;
					4'd1, 4'd3: begin
						n_data = 1'b1;
						n_word = {8'h00, (cur_step == 4'd1 ? head_data.w0[15:8]
							: head_data.w1[15:8])};
					end
					4'd2, 4'd4: begin
						n_data = 1'b1;
						n_word = {8'h00, (cur_step == 4'd2 ? head_data.w0[7:0]
							: head_data.w1[7:0])};
					end
					4'd6, 4'd8: begin
						n_data = 1'b1;
						n_word = {8'h00, (cur_step == 4'd6 ? head_data.w2[15:8]
							: head_data.w3[15:8])};
					end
					4'd7, 4'd9: begin
						n_data = 1'b1;
						n_word = {8'h00, (cur_step == 4'd7 ? head_data.w2[7:0]
							: head_data.w3[7:0])};
					end
					default: n_word = lcdw_pkg::CMD_MEMWR;
				endcase
			end
			default: begin
				n_word = head_data.w0;
			end
		endcase
	end

	assign n_last  = (cur_step == last_step);
	assign advance = head_valid && (!valid_q || !word_stall);
	assign pop     = advance && n_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			step_q   <= '0;
			valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				valid_q  <= 1'b1;
				active_q <= !n_last;
				step_q   <= cur_step + 1'b1;
			end else if (!word_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_q  <= n_data;
			color_q <= n_color;
			last_q  <= n_last;
			word_q  <= n_word;
		end
	end

	assign word_valid = valid_q;
	assign is_data    = data_q;
	assign is_color   = color_q;
	assign last       = last_q;
	assign bus_word   = word_q;

endmodule
